// ----- hdl/thpm_pkg.sv -----
// Package with the shared constants, types and helpers of the tiled homography point map.
`default_nettype none
package thpm_pkg;

    localparam int GRID_COLS      = 4;
    localparam int GRID_TILES     = 16;
    localparam int GRID_ROWS      = GRID_TILES / GRID_COLS;
    localparam int COEFS_PER_TILE = 9;
    localparam int TABLE_SIZE     = COEFS_PER_TILE * GRID_TILES;

    localparam int COL_W  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int TILE_W = (GRID_TILES > 1) ? $clog2(GRID_TILES) : 1;
    localparam int ELEM_W = $clog2(COEFS_PER_TILE);

    localparam int COORD_W = 12;
    localparam int IDX_W   = 8;
    localparam int COEF_W  = 32;
    localparam int CFG_IDX_W = 8;
    localparam int PROD_W  = COEF_W + COORD_W + 1;
    localparam int SUM_W   = PROD_W + 2;
    localparam int NUM_W   = SUM_W + 5;
    localparam int DEN_W   = SUM_W + 1;
    localparam int Q_W     = 20;
    localparam int OUT_W   = 20;

    localparam logic [COORD_W-1:0] TILE_WIDTH_RESET  = COORD_W'(480);
    localparam logic [COORD_W-1:0] TILE_HEIGHT_RESET = COORD_W'(270);
    localparam logic [Q_W-1:0]     OUT_POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0]     OUT_NEG_MAG = {1'b1, {(Q_W-1){1'b0}}};

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_POINT = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TILE_WIDTH  = CFG_IDX_W'(0),
        REG_TILE_HEIGHT = CFG_IDX_W'(1)
    } t_cfg_reg;

    typedef logic [COEF_W-1:0] t_coef;

    typedef struct packed {
        logic                              valid;
        logic [COORD_W-1:0]                x;
        logic [COORD_W-1:0]                y;
        t_coef [COEFS_PER_TILE-1:0]        coef;
    } t_tile_out;

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic             neg;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_in;

    typedef struct packed {
        logic           valid;
        logic           zero;
        logic           neg;
        logic           sat;
        logic [Q_W-1:0] q;
    } t_div_out;

    function automatic logic [TILE_W-1:0] coef_tile(input logic [IDX_W-1:0] idx);
        logic [TILE_W-1:0] t;
        t = '0;
        for (int k = 1; k < GRID_TILES; k++) begin
            if (int'(idx) >= k * COEFS_PER_TILE) begin
                t = TILE_W'(k);
            end
        end
        return t;
    endfunction

    function automatic logic [ELEM_W-1:0] coef_elem(input logic [IDX_W-1:0] idx);
        logic [TILE_W-1:0] t;
        logic [IDX_W-1:0]  base;
        t = coef_tile(idx);
        base = IDX_W'(int'(t) * COEFS_PER_TILE);
        return ELEM_W'(idx - base);
    endfunction

endpackage
`default_nettype wire

// ----- hdl/tiled_homography_point_map.sv -----
// Top level of the tiled homography point map: configuration, pipeline and result stage.
// Throughput: one transaction per cycle; busy stays low since every stage is pipelined.
// Coefficient writes take effect for the next transaction and produce no result.
// Reset is synchronous and active low; it restores tile size 480 by 270 and clears valid bits.
// The receiver cannot stall, so results are never held back.
`default_nettype none
module tiled_homography_point_map (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output wire logic                              busy,
    input  wire logic                              i_opcode,
    input  wire logic [thpm_pkg::IDX_W-1:0]        i_coef_index,
    input  wire logic signed [thpm_pkg::COEF_W-1:0] i_coef_value,
    input  wire logic [thpm_pkg::COORD_W-1:0]      i_point_x,
    input  wire logic [thpm_pkg::COORD_W-1:0]      i_point_y,
    input  wire logic                              i_cfg_valid,
    output wire logic                              o_cfg_ready,
    input  wire logic [thpm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [thpm_pkg::COORD_W-1:0]      i_cfg_data,
    output wire logic                              o_strobe,
    output wire logic signed [thpm_pkg::OUT_W-1:0] o_mapped_x,
    output wire logic signed [thpm_pkg::OUT_W-1:0] o_mapped_y,
    output wire logic                              o_zero_denominator,
    output wire logic                              o_saturated
);
    import thpm_pkg::*;

    logic [COORD_W-1:0] r_tile_width;
    logic [COORD_W-1:0] r_tile_height;
    logic               n_accept;
    t_tile_out          s_tile;
    t_div_in            s_div_x;
    t_div_in            s_div_y;
    t_div_out           s_res_x;
    t_div_out           s_res_y;

    logic               r_strobe;
    logic [OUT_W-1:0]   r_mx;
    logic [OUT_W-1:0]   r_my;
    logic               r_zero;
    logic               r_sat;
    logic [OUT_W-1:0]   n_mx;
    logic [OUT_W-1:0]   n_my;
    logic               n_sat_x;
    logic               n_sat_y;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign n_accept    = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_width  <= TILE_WIDTH_RESET;
            r_tile_height <= TILE_HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_TILE_WIDTH) begin
                r_tile_width <= i_cfg_data;
            end else if (i_cfg_index == REG_TILE_HEIGHT) begin
                r_tile_height <= i_cfg_data;
            end
        end
    end

    thpm_tile u_tile (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_en       (n_accept && (i_opcode == OP_WRITE)),
        .i_wr_index    (i_coef_index),
        .i_wr_value    (i_coef_value),
        .i_pt_valid    (n_accept && (i_opcode == OP_POINT)),
        .i_x           (i_point_x),
        .i_y           (i_point_y),
        .i_tile_width  (r_tile_width),
        .i_tile_height (r_tile_height),
        .o_tile        (s_tile)
    );

    thpm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tile  (s_tile),
        .o_div_x (s_div_x),
        .o_div_y (s_div_y)
    );

    thpm_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_div   (s_div_x),
        .o_div   (s_res_x)
    );

    thpm_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_div   (s_div_y),
        .o_div   (s_res_y)
    );

    always_comb begin
        if (s_res_x.neg) begin
            n_sat_x = s_res_x.sat || (s_res_x.q > OUT_NEG_MAG);
            n_mx    = n_sat_x ? OUT_W'(-OUT_NEG_MAG) : OUT_W'(-s_res_x.q);
        end else begin
            n_sat_x = s_res_x.sat || (s_res_x.q > OUT_POS_MAX);
            n_mx    = n_sat_x ? OUT_POS_MAX : s_res_x.q;
        end
        if (s_res_y.neg) begin
            n_sat_y = s_res_y.sat || (s_res_y.q > OUT_NEG_MAG);
            n_my    = n_sat_y ? OUT_W'(-OUT_NEG_MAG) : OUT_W'(-s_res_y.q);
        end else begin
            n_sat_y = s_res_y.sat || (s_res_y.q > OUT_POS_MAX);
            n_my    = n_sat_y ? OUT_POS_MAX : s_res_y.q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= s_res_x.valid;
        end
        r_zero <= s_res_x.zero;
        r_sat  <= !s_res_x.zero && (n_sat_x || n_sat_y);
        r_mx   <= s_res_x.zero ? '0 : n_mx;
        r_my   <= s_res_x.zero ? '0 : n_my;
    end

    assign o_strobe           = r_strobe;
    assign o_mapped_x         = $signed(r_mx);
    assign o_mapped_y         = $signed(r_my);
    assign o_zero_denominator = r_zero;
    assign o_saturated        = r_sat;

endmodule
`default_nettype wire

// ----- hdl/thpm_tile.sv -----
// Tile selection and banked coefficient table with registered reads.
`default_nettype none
module thpm_tile (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr_en,
    input  wire logic [thpm_pkg::IDX_W-1:0]    i_wr_index,
    input  wire logic [thpm_pkg::COEF_W-1:0]   i_wr_value,
    input  wire logic                          i_pt_valid,
    input  wire logic [thpm_pkg::COORD_W-1:0]  i_x,
    input  wire logic [thpm_pkg::COORD_W-1:0]  i_y,
    input  wire logic [thpm_pkg::COORD_W-1:0]  i_tile_width,
    input  wire logic [thpm_pkg::COORD_W-1:0]  i_tile_height,
    output thpm_pkg::t_tile_out                o_tile
);
    import thpm_pkg::*;

    localparam int THR_W = COORD_W + COL_W + ROW_W;

    t_coef r_bank [COEFS_PER_TILE][GRID_TILES];

    logic [COL_W-1:0]   n_col;
    logic [ROW_W-1:0]   n_row;
    logic [TILE_W-1:0]  n_tile;
    logic [TILE_W-1:0]  r_tile;
    logic               r_v1;
    logic [COORD_W-1:0] r_x1;
    logic [COORD_W-1:0] r_y1;
    logic               r_v2;
    logic [COORD_W-1:0] r_x2;
    logic [COORD_W-1:0] r_y2;
    t_coef [COEFS_PER_TILE-1:0] r_rd;

    always_comb begin
        logic [THR_W-1:0] thr;
        n_col = '0;
        n_row = '0;
        for (int k = 1; k < GRID_COLS; k++) begin
            thr = THR_W'(k) * THR_W'(i_tile_width);
            if (THR_W'(i_x) >= thr) begin
                n_col = COL_W'(k);
            end
        end
        for (int k = 1; k < GRID_ROWS; k++) begin
            thr = THR_W'(k) * THR_W'(i_tile_height);
            if (THR_W'(i_y) >= thr) begin
                n_row = ROW_W'(k);
            end
        end
        if (i_tile_width == '0) begin
            n_col = COL_W'(GRID_COLS - 1);
        end
        if (i_tile_height == '0) begin
            n_row = ROW_W'(GRID_ROWS - 1);
        end
        n_tile = TILE_W'(n_col) + TILE_W'(int'(n_row) * GRID_COLS);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (int'(i_wr_index) < TABLE_SIZE)) begin
            r_bank[coef_elem(i_wr_index)][coef_tile(i_wr_index)] <= i_wr_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_pt_valid;
            r_v2 <= r_v1;
        end
        r_tile <= n_tile;
        r_x1   <= i_x;
        r_y1   <= i_y;
        r_x2   <= r_x1;
        r_y2   <= r_y1;
        for (int e = 0; e < COEFS_PER_TILE; e++) begin
            r_rd[e] <= r_bank[e][r_tile];
        end
    end

    assign o_tile.valid = r_v2;
    assign o_tile.x     = r_x2;
    assign o_tile.y     = r_y2;
    assign o_tile.coef  = r_rd;

endmodule
`default_nettype wire

// ----- hdl/thpm_mac.sv -----
// Products, sums and divider operand preparation for one point.
`default_nettype none
module thpm_mac (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire thpm_pkg::t_tile_out i_tile,
    output thpm_pkg::t_div_in       o_div_x,
    output thpm_pkg::t_div_in       o_div_y
);
    import thpm_pkg::*;

    logic                     r_v3;
    logic signed [PROD_W-1:0] r_prod [COEFS_PER_TILE];
    logic                     r_v4;
    logic signed [SUM_W-1:0]  r_nx;
    logic signed [SUM_W-1:0]  r_ny;
    logic signed [SUM_W-1:0]  r_w;
    t_div_in                  r_dx;
    t_div_in                  r_dy;

    logic [SUM_W-1:0] n_mag_x;
    logic [SUM_W-1:0] n_mag_y;
    logic [SUM_W-1:0] n_mag_w;

    always_comb begin
        n_mag_x = r_nx[SUM_W-1] ? SUM_W'(-r_nx) : SUM_W'(r_nx);
        n_mag_y = r_ny[SUM_W-1] ? SUM_W'(-r_ny) : SUM_W'(r_ny);
        n_mag_w = r_w[SUM_W-1]  ? SUM_W'(-r_w)  : SUM_W'(r_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3       <= 1'b0;
            r_v4       <= 1'b0;
            r_dx.valid <= 1'b0;
            r_dy.valid <= 1'b0;
        end else begin
            r_v3       <= i_tile.valid;
            r_v4       <= r_v3;
            r_dx.valid <= r_v4;
            r_dy.valid <= r_v4;
        end
        for (int e = 0; e < COEFS_PER_TILE; e++) begin
            if (e % 3 == 0) begin
                r_prod[e] <= $signed(i_tile.coef[e]) * $signed({1'b0, i_tile.x});
            end else if (e % 3 == 1) begin
                r_prod[e] <= $signed(i_tile.coef[e]) * $signed({1'b0, i_tile.y});
            end else begin
                r_prod[e] <= PROD_W'($signed(i_tile.coef[e]));
            end
        end
        r_nx <= SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]) + SUM_W'(r_prod[2]);
        r_ny <= SUM_W'(r_prod[3]) + SUM_W'(r_prod[4]) + SUM_W'(r_prod[5]);
        r_w  <= SUM_W'(r_prod[6]) + SUM_W'(r_prod[7]) + SUM_W'(r_prod[8]);
        r_dx.zero <= (r_w == '0);
        r_dy.zero <= (r_w == '0);
        r_dx.neg  <= r_nx[SUM_W-1] ^ r_w[SUM_W-1];
        r_dy.neg  <= r_ny[SUM_W-1] ^ r_w[SUM_W-1];
        r_dx.num  <= {n_mag_x, 5'b0} + NUM_W'(n_mag_w);
        r_dy.num  <= {n_mag_y, 5'b0} + NUM_W'(n_mag_w);
        r_dx.den  <= {n_mag_w, 1'b0};
        r_dy.den  <= {n_mag_w, 1'b0};
    end

    assign o_div_x = r_dx;
    assign o_div_y = r_dy;

endmodule
`default_nettype wire

// ----- hdl/thpm_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow check.
`default_nettype none
module thpm_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire thpm_pkg::t_div_in i_div,
    output thpm_pkg::t_div_out     o_div
);
    import thpm_pkg::*;

    localparam int CMP_W = DEN_W + Q_W;

    logic             r_v    [Q_W+1];
    logic             r_zero [Q_W+1];
    logic             r_neg  [Q_W+1];
    logic             r_sat  [Q_W+1];
    logic [NUM_W-1:0] r_rem  [Q_W+1];
    logic [DEN_W-1:0] r_den  [Q_W+1];
    logic [Q_W-1:0]   r_q    [Q_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_div.valid;
        end
        r_zero[0] <= i_div.zero;
        r_neg[0]  <= i_div.neg;
        r_sat[0]  <= CMP_W'(i_div.num) >= (CMP_W'(i_div.den) << Q_W);
        r_rem[0]  <= i_div.num;
        r_den[0]  <= i_div.den;
        r_q[0]    <= '0;
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_stage
        logic [CMP_W-1:0] n_shift;
        logic             n_ge;
        always_comb begin
            n_shift = CMP_W'(r_den[k-1]) << (Q_W - k);
            n_ge    = CMP_W'(r_rem[k-1]) >= n_shift;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
            r_zero[k] <= r_zero[k-1];
            r_neg[k]  <= r_neg[k-1];
            r_sat[k]  <= r_sat[k-1];
            r_den[k]  <= r_den[k-1];
            r_rem[k]  <= n_ge ? NUM_W'(CMP_W'(r_rem[k-1]) - n_shift) : r_rem[k-1];
            r_q[k]    <= r_q[k-1] | (n_ge ? (Q_W'(1) << (Q_W - k)) : '0);
        end
    end

    assign o_div.valid = r_v[Q_W];
    assign o_div.zero  = r_zero[Q_W];
    assign o_div.neg   = r_neg[Q_W];
    assign o_div.sat   = r_sat[Q_W];
    assign o_div.q     = r_q[Q_W];

endmodule
`default_nettype wire
